// File: rtl/dct_pkg.sv
`default_nettype none
package dct_pkg;
   localparam int N = 8;
   localparam int ELEMS = N * N;
   localparam int IDX_W = 6;
   localparam int LINE_W = 3;
   localparam int SAMPLE_W = 20;
   localparam int TRANS_W = 24;
   localparam int COEF_W = 15;
   localparam int ACC_W = 44;
   localparam int FRAC = 14;

   typedef logic signed [COEF_W-1:0] coef_type;

   function automatic coef_type half_cos(input logic [3:0] m);
      case (m)
         4'd0: half_cos = 15'sd8192;
         4'd1: half_cos = 15'sd8035;
         4'd2: half_cos = 15'sd7568;
         4'd3: half_cos = 15'sd6811;
         4'd4: half_cos = 15'sd5793;
         4'd5: half_cos = 15'sd4551;
         4'd6: half_cos = 15'sd3135;
         4'd7: half_cos = 15'sd1598;
         default: half_cos = 15'sd0;
      endcase
   endfunction

   // w(k,n) = c(k) * cos(pi*(2n+1)*k/16) in Q1.14
   function automatic coef_type basis(input logic [2:0] k, input logic [2:0] n);
      logic [4:0] m;
      logic [4:0] mm;
      logic [7:0] prod;
      prod = ({4'd0, n, 1'b1}) * {5'd0, k};
      m = prod[4:0];
      mm = (m > 5'd16) ? 5'd0 - m : m;
      if (k == 3'd0) basis = 15'sd5793;
      else if (mm > 5'd8) basis = -half_cos(4'(5'd16 - mm));
      else basis = half_cos(mm[3:0]);
   endfunction

   typedef struct packed {
      logic           start;
      logic           col_pass;
      logic           inverse;
   } pass_ctl_type;
endpackage
`default_nettype wire

// File: rtl/dct_ram.sv
`default_nettype none
module dct_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

// File: rtl/dct_mac.sv
`default_nettype none
module dct_mac
   import dct_pkg::*;
(
   input  wire logic                       clock,
   input  wire logic                       clear,
   input  wire logic                       en,
   input  wire logic signed [TRANS_W-1:0]  x,
   input  wire logic [2:0]                 k,
   input  wire logic [2:0]                 n,
   output logic signed [TRANS_W-1:0]       sat24,
   output logic signed [SAMPLE_W-1:0]      sat20
);
   logic signed [TRANS_W+COEF_W-1:0] prod_ff, prod_in;
   logic signed [ACC_W-1:0] acc_ff, acc_in, rnd;

   assign prod_in = x * basis(k, n);
   always_comb begin
      acc_in = acc_ff;
      if (clear) acc_in = '0;
      if (en) acc_in = acc_in + ACC_W'(prod_ff);
   end
   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

   // round half up, then clamp
   assign rnd = (acc_ff + ACC_W'(1 << (FRAC - 1))) >>> FRAC;
   always_comb begin
      if (rnd > ACC_W'((1 << (TRANS_W - 1)) - 1)) sat24 = {1'b0, {(TRANS_W-1){1'b1}}};
      else if (rnd < -ACC_W'(1 << (TRANS_W - 1))) sat24 = {1'b1, {(TRANS_W-1){1'b0}}};
      else sat24 = rnd[TRANS_W-1:0];
      if (rnd > ACC_W'((1 << (SAMPLE_W - 1)) - 1)) sat20 = {1'b0, {(SAMPLE_W-1){1'b1}}};
      else if (rnd < -ACC_W'(1 << (SAMPLE_W - 1))) sat20 = {1'b1, {(SAMPLE_W-1){1'b0}}};
      else sat20 = rnd[SAMPLE_W-1:0];
   end
endmodule
`default_nettype wire

// File: rtl/dct_2d_block_transform_core.sv
`default_nettype none
// channel | dir | tdata bits                      | tuser / tlast
// req     | in  | sample_value [19:0]             | -
// rsp     | out | coeff_value [19:0], index[25:20]| tlast = last_of_block
// csr     | in  | direction [0]                   | -
// Loading takes one item per cycle while the sender offers samples. The two
// passes then run the multiply-accumulates through the block and transpose RAMs:
// each output reads its eight taps, drains the pipeline and then writes the
// result. Then the 64 results are read out (RAM read, then output register)
// when the sink is ready; a new read is not issued before the last one has
// reached the output register. Reset clears counters and the direction; RAM
// contents are undefined. A rsp stall holds the read-out.
module dct_2d_block_transform_core
   import dct_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [23:0] req_tdata,   // sample_value[19:0]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata,   // coeff_value[19:0], coeff_index[25:20]
   output logic             rsp_tlast,   // last_of_block
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic        csr_data     // direction
);
   localparam logic [2:0] S_LOAD = 3'd0, S_CALC = 3'd1, S_EMIT = 3'd2;

   logic [2:0] state_ff, state_in;
   logic [IDX_W:0] cnt_ff, cnt_in;
   logic dir_ff, inv_ff, inv_in, pass_ff, pass_in;
   // calc counters: output element e (line, a) and tap b, plus drain
   logic [IDX_W-1:0] elem_ff, elem_in;
   logic [3:0] tap_ff, tap_in;

   logic b_we; logic [IDX_W-1:0] b_wa, b_ra; logic [SAMPLE_W-1:0] b_wd, b_rd;
   logic t_we; logic [IDX_W-1:0] t_wa, t_ra; logic [TRANS_W-1:0] t_wd, t_rd;

   logic [2:0] line_i, out_a, tap_b;
   logic signed [TRANS_W-1:0] x;
   logic signed [TRANS_W-1:0] s24;
   logic signed [SAMPLE_W-1:0] s20;
   logic mac_clear, mac_en, d1_ff, d2_ff;
   logic [2:0] k_ff, n_ff;

   // output pipeline: rsp register fed by RAM read
   logic rv_ff, rv_in, rl_ff, rl_in, rd_pend_ff, rd_pend_in;
   logic [IDX_W-1:0] ri_ff, ri_in, pend_idx_ff, pend_idx_in;
   logic [SAMPLE_W-1:0] rdat_ff, rdat_in;

   pass_ctl_type ctl;

   assign line_i = elem_ff[5:3];
   assign out_a  = elem_ff[2:0];
   assign tap_b  = tap_ff[2:0];
   assign ctl    = '{start: (state_ff == S_CALC), col_pass: pass_ff, inverse: inv_ff};

   dct_ram #(.WIDTH(SAMPLE_W), .DEPTH(ELEMS)) u_block (
      .clock, .wr_en(b_we), .wr_addr(b_wa), .wr_data(b_wd), .rd_addr(b_ra), .rd_data(b_rd));
   dct_ram #(.WIDTH(TRANS_W), .DEPTH(ELEMS)) u_trans (
      .clock, .wr_en(t_we), .wr_addr(t_wa), .wr_data(t_wd), .rd_addr(t_ra), .rd_data(t_rd));

   dct_mac u_mac (.clock, .clear(mac_clear), .en(mac_en), .x(x), .k(k_ff), .n(n_ff),
      .sat24(s24), .sat20(s20));

   assign csr_ready  = (state_ff == S_LOAD);
   assign req_tready = (state_ff == S_LOAD);
   assign x = ctl.col_pass ? t_rd : TRANS_W'(signed'(b_rd));

   // tap pipeline stages in order: read address, data, product reg, acc
   always_ff @(posedge clock) begin
      // basis indices aligned to RAM data
      k_ff <= ctl.inverse ? tap_b : out_a;
      n_ff <= ctl.inverse ? out_a : tap_b;
      d1_ff <= ctl.start && (tap_ff < 4'd8);
      d2_ff <= d1_ff;
   end
   assign mac_clear = (state_ff == S_CALC) && (tap_ff == 4'd0);
   assign mac_en = d2_ff;

   always_comb begin
      state_in = state_ff; cnt_in = cnt_ff; inv_in = inv_ff; pass_in = pass_ff;
      elem_in = elem_ff; tap_in = tap_ff;
      b_we = 1'b0; b_wa = cnt_ff[IDX_W-1:0]; b_wd = req_tdata[SAMPLE_W-1:0];
      t_we = 1'b0; t_wa = {out_a, line_i}; t_wd = s24;
      b_ra = {line_i, tap_b}; t_ra = {line_i, tap_b};
      rv_in = rv_ff; rl_in = rl_ff; ri_in = ri_ff; rdat_in = rdat_ff;
      rd_pend_in = 1'b0; pend_idx_in = pend_idx_ff;
      if (rv_ff && rsp_tready) rv_in = 1'b0;
      case (state_ff)
         S_LOAD: begin
            if (req_tvalid) begin
               b_we = 1'b1;
               if (cnt_ff == 7'(ELEMS - 1)) begin
                  cnt_in = '0; inv_in = dir_ff; pass_in = 1'b0;
                  elem_in = '0; tap_in = '0; state_in = S_CALC;
               end else cnt_in = cnt_ff + 7'd1;
            end
         end
         S_CALC: begin
            // taps 0..7 issue reads, 8..10 drain, 11 writes result
            if (tap_ff == 4'd11) begin
               if (pass_ff) begin
                  b_we = 1'b1; b_wa = {out_a, line_i}; b_wd = s20;
               end else t_we = 1'b1;
               tap_in = '0;
               elem_in = elem_ff + 6'd1;
               if (elem_ff == 6'(ELEMS - 1)) begin
                  if (pass_ff) begin
                     state_in = S_EMIT; cnt_in = '0;
                  end else pass_in = 1'b1;
               end
            end else tap_in = tap_ff + 4'd1;
         end
         S_EMIT: begin
            b_ra = cnt_ff[IDX_W-1:0];
            if (rd_pend_ff) begin
               rv_in = 1'b1; rdat_in = b_rd; ri_in = pend_idx_ff;
               rl_in = (pend_idx_ff == 6'(ELEMS - 1));
            end
            if (!rd_pend_ff && (!rv_ff || rsp_tready)) begin
               if (cnt_ff == 7'(ELEMS)) begin
                  if (!rv_ff || rsp_tready) begin
                     state_in = S_LOAD; cnt_in = '0;
                  end
               end else begin
                  rd_pend_in = 1'b1; pend_idx_in = cnt_ff[IDX_W-1:0];
                  cnt_in = cnt_ff + 7'd1;
               end
            end
         end
         default: state_in = S_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_LOAD; cnt_ff <= '0; dir_ff <= 1'b0; inv_ff <= 1'b0;
         pass_ff <= 1'b0; elem_ff <= '0; tap_ff <= '0; rv_ff <= 1'b0;
         rd_pend_ff <= 1'b0;
      end else begin
         state_ff <= state_in; cnt_ff <= cnt_in; inv_ff <= inv_in;
         pass_ff <= pass_in; elem_ff <= elem_in; tap_ff <= tap_in;
         rv_ff <= rv_in; rd_pend_ff <= rd_pend_in;
         if (csr_valid && csr_ready) dir_ff <= csr_data;
      end
      rl_ff <= rl_in; ri_ff <= ri_in; rdat_ff <= rdat_in; pend_idx_ff <= pend_idx_in;
   end

   assign rsp_tvalid = rv_ff;
   assign rsp_tdata  = {6'd0, ri_ff, rdat_ff};
   assign rsp_tlast  = rl_ff;
endmodule
`default_nettype wire

// File: rtl/dct_checker.sv
`default_nettype none
module dct_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [31:0] rsp_tdata,
   input wire logic        rsp_tlast
);
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready) else $error("load during read-out");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result dropped");
   a_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tlast == (rsp_tdata[25:20] == 6'd63)))
      else $error("last mark wrong");
   a_seq: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast ##1 rsp_tvalid
      |-> rsp_tdata[25:20] == $past(rsp_tdata[25:20]) + 6'd1)
      else $error("index out of order");
endmodule
bind dct_2d_block_transform_core dct_checker u_checker (.*);
`default_nettype wire

// File: test/dct_block_checker.sv
`timescale 1ns / 1ps
module dct_block_checker
   import dct_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   input  wire logic        req_tready,
   input  wire logic [23:0] req_tdata,
   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic [31:0] rsp_tdata,
   input  wire logic        rsp_tlast,
   input  wire logic        csr_valid,
   input  wire logic        csr_ready,
   input  wire logic        csr_data,
   output int               fail_count,
   output int               pending
);
   typedef struct packed {
      logic [19:0] value;
      logic [5:0]  index;
      logic        last;
   } coeff_item_type;

   localparam longint HALF_COS [0:8] = '{8192, 8035, 7568, 6811, 5793, 4551, 3135, 1598, 0};

   coeff_item_type coeff_expected[$];
   longint         sample_buf[64];
   longint         row_pass[64];
   int             fill_count;
   logic           dir_inverse;

   function automatic longint weight(int k, int n);
      int m;
      if (k == 0) return 5793;
      m = ((2 * n + 1) * k) % 32;
      if (m > 16) m = 32 - m;
      if (m > 8) return -HALF_COS[16 - m];
      return HALF_COS[m];
   endfunction

   function automatic longint round_sat(longint acc, int w);
      longint v;
      longint hi;
      v = (acc + 8192) >>> 14;
      hi = (longint'(1) <<< (w - 1)) - 1;
      if (v > hi) return hi;
      if (v < -hi - 1) return -hi - 1;
      return v;
   endfunction

   // row pass into the transpose buffer, column pass back, then queue 64 results
   task automatic predict_block();
      longint acc;
      longint res[64];
      coeff_item_type item;
      for (int i = 0; i < 8; i++)
         for (int j = 0; j < 8; j++) begin
            acc = 0;
            for (int b = 0; b < 8; b++)
               acc += sample_buf[i*8+b] * (dir_inverse ? weight(b, j) : weight(j, b));
            row_pass[j*8+i] = round_sat(acc, 24);
         end
      for (int i = 0; i < 8; i++)
         for (int j = 0; j < 8; j++) begin
            acc = 0;
            for (int b = 0; b < 8; b++)
               acc += row_pass[i*8+b] * (dir_inverse ? weight(b, j) : weight(j, b));
            res[j*8+i] = round_sat(acc, 20);
         end
      for (int e = 0; e < 64; e++) begin
         item.value = res[e][19:0];
         item.index = e[5:0];
         item.last  = (e == 63);
         coeff_expected.push_back(item);
      end
   endtask

   always @(posedge clock) begin
      coeff_item_type want;
      if (reset) begin
         fill_count  = 0;
         dir_inverse = 1'b0;
         fail_count  = 0;
         coeff_expected.delete();
      end else begin
         if (csr_valid && csr_ready) dir_inverse = csr_data;
         if (req_tvalid && req_tready) begin
            sample_buf[fill_count] = longint'($signed(req_tdata[19:0]));
            if (fill_count == 63) begin
               predict_block();
               fill_count = 0;
            end else begin
               fill_count = fill_count + 1;
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            if (coeff_expected.size() == 0) begin
               $display("%0t: unexpected result, expected none, got %h last %b",
                        $time, rsp_tdata, rsp_tlast);
               fail_count = fail_count + 1;
            end else begin
               want = coeff_expected.pop_front();
               if (rsp_tdata[19:0] !== want.value || rsp_tdata[25:20] !== want.index
                   || rsp_tlast !== want.last) begin
                  $display("%0t: mismatch, expected value %h index %0d last %b, got value %h index %0d last %b",
                           $time, want.value, want.index, want.last,
                           rsp_tdata[19:0], rsp_tdata[25:20], rsp_tlast);
                  fail_count = fail_count + 1;
               end
            end
         end
      end
      pending = coeff_expected.size();
   end
endmodule

// File: test/dct_2d_block_transform_core_tb.sv
`timescale 1ns / 1ps
module dct_2d_block_transform_core_tb;
   import dct_pkg::*;

   localparam int IDLE_LIMIT = 20000;
   localparam int LONG_HOLD  = 3000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;   // sample_value[19:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;       // coeff_value[19:0], coeff_index[25:20]
   logic        rsp_tlast;       // last_of_block
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic        csr_data = 1'b0;  // direction

   int          fail_count;
   int          pending;
   int          burst_left = 0;
   int          idle_cycles = 0;
   int          hold_cnt = 0;
   bit          long_hold_req = 0;
   logic [31:0] cyc = 0;

   always #6 clock = ~clock;

   dct_2d_block_transform_core u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   dct_block_checker u_checker (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data),
      .fail_count(fail_count), .pending(pending)
   );

   // Receiver: long hold-off on request, otherwise a pattern that cycles through
   // always-ready, light stalling, heavy stalling and alternating ready.
   always @(posedge clock) begin
      cyc <= cyc + 1;
      if (long_hold_req) begin
         long_hold_req = 0;
         hold_cnt = LONG_HOLD;
      end
      if (hold_cnt > 0) begin
         hold_cnt = hold_cnt - 1;
         rsp_tready <= 1'b0;
      end else begin
         case (cyc[8:7])
            2'd0: rsp_tready <= 1'b1;
            2'd1: rsp_tready <= ($urandom_range(0, 3) != 0);
            2'd2: rsp_tready <= ($urandom_range(0, 3) == 0);
            default: rsp_tready <= cyc[2];
         endcase
      end
   end

   // Watchdog: count cycles with no handshake on any channel.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // Offer one sample; open a gap first once the current burst runs out.
   task automatic send_sample(input logic [19:0] v);
      bit ok;
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 6);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 3) == 0) ? 64 : $urandom_range(1, 12);
      end
      burst_left = burst_left - 1;
      req_tvalid <= 1'b1;
      req_tdata  <= {4'd0, v};
      do begin
         @(negedge clock);
         ok = req_tready;
         @(posedge clock);
      end while (!ok);
   endtask

   // Hold until every expected result has arrived and the core has settled.
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_direction(input logic d);
      bit ok;
      csr_valid <= 1'b1;
      csr_data  <= d;
      do begin
         @(negedge clock);
         ok = csr_ready;
         @(posedge clock);
      end while (!ok);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [19:0] random_sample();
      case ($urandom_range(0, 3))
         0: return 20'($urandom);
         1: return 20'($signed($urandom_range(0, 4095)) - 2048);
         2: return $urandom_range(0, 1) ? 20'h7ffff : 20'h80000;
         default: return 20'($signed($urandom_range(0, 131071)) - 65536);
      endcase
   endfunction

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Forward transform: extremes up front, then a saturating checkerboard.
      write_direction(1'b0);
      send_sample(20'h7ffff);
      send_sample(20'h80000);
      send_sample(20'h00000);
      send_sample(20'hfffff);
      send_sample(20'h00001);
      for (int e = 5; e < 64; e++)
         send_sample((((e >> 3) + e) & 1) ? 20'h80000 : 20'h7ffff);
      wait_drained();

      // Inverse transform of a flat maximal block under a long receiver
      // hold-off, while the sender keeps offering a random block behind it.
      write_direction(1'b1);
      long_hold_req = 1;
      for (int e = 0; e < 64; e++) send_sample(20'h7ffff);
      for (int e = 0; e < 64; e++) send_sample(random_sample());
      wait_drained();
      write_direction(1'b0);

      repeat (100) @(posedge clock);
      if (fail_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end
endmodule
